@@ src/binding_layout_merge_table_core_assert.svh @@
// Assertion macros for the binding layout merge table core.
`ifndef BINDING_LAYOUT_MERGE_TABLE_CORE_ASSERT_SVH
`define BINDING_LAYOUT_MERGE_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define BLMT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("blmt assertion failed");

// antecedent in one cycle implies consequent in the next
`define BLMT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blmt assertion failed");

`else

`define BLMT_ASSERT(name, clk, rst, prop)
`define BLMT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ src/blmt_pkg.sv @@
package blmt_pkg;

  localparam int RES_ENTRIES = 16;
  localparam int RNG_ENTRIES = 8;
  localparam int STAGE_BITS  = 8;

  localparam int RES_AW = $clog2(RES_ENTRIES);
  localparam int RNG_AW = $clog2(RNG_ENTRIES);
  localparam int RES_CW = $clog2(RES_ENTRIES + 1);
  localparam int RNG_CW = $clog2(RNG_ENTRIES + 1);

  localparam int MODE_W      = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    MODE_BEGIN   = 3'd0,
    MODE_ADD_RES = 3'd1,
    MODE_ADD_RNG = 3'd2,
    MODE_RD_RES  = 3'd3,
    MODE_RD_RNG  = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_TYPE     = 3'd2,
    ST_SIZE     = 3'd3,
    ST_OVERLAP  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  stage_mask;
    logic [3:0]  set_number;
    logic [9:0]  binding_number;
    logic [3:0]  resource_kind;
    logic [15:0] array_count;
    logic [7:0]  range_offset;
    logic [8:0]  range_bytes;
    logic [3:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        entry_valid;
    logic [3:0]  out_set;
    logic [9:0]  out_binding;
    logic [3:0]  out_kind;
    logic [15:0] out_array_count;
    logic [7:0]  out_offset;
    logic [8:0]  out_bytes;
    logic [7:0]  out_stages;
    logic [4:0]  entry_total;
  } result_t;

  typedef struct packed {
    logic [3:0]            set_number;
    logic [9:0]            binding_number;
    logic [3:0]            resource_kind;
    logic [15:0]           array_count;
    logic [STAGE_BITS-1:0] stages;
  } res_entry_t;

  typedef struct packed {
    logic [7:0]            range_offset;
    logic [8:0]            range_bytes;
    logic [STAGE_BITS-1:0] stages;
  } rng_entry_t;

  localparam int RES_W = $bits(res_entry_t);
  localparam int RNG_W = $bits(rng_entry_t);

endpackage

@@ src/blmt_ram.sv @@
module blmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/blmt_seq.sv @@
`include "binding_layout_merge_table_core_assert.svh"

module blmt_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  blmt_pkg::req_t    req,
  output logic              req_ready,
  input  logic              out_free,
  output logic              rsp_valid,
  output blmt_pkg::result_t rsp
);

  import blmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  req_t                  item;
  result_t               rslt;
  status_t               err;
  logic [RES_CW-1:0]     res_count;
  logic [RNG_CW-1:0]     rng_count;
  logic [STAGE_BITS-1:0] seen;
  logic [STAGE_BITS-1:0] cur;
  logic [RES_CW-1:0]     scan_idx;
  logic [RES_AW-1:0]     pend_idx;
  logic                  pend;
  logic                  ovl;

  logic                  res_we, res_re;
  logic [RES_AW-1:0]     res_waddr, res_raddr;
  res_entry_t            res_wdata, res_rd;
  logic [RES_W-1:0]      res_rdata;
  logic                  rng_we, rng_re;
  logic [RNG_AW-1:0]     rng_waddr, rng_raddr;
  rng_entry_t            rng_wdata, rng_rd;
  logic [RNG_W-1:0]      rng_rdata;

  logic [RES_CW-1:0]     scan_cnt;
  logic                  is_res, is_rng, issue, scan_end;
  logic                  res_full, rng_full, res_idx_ok, rng_idx_ok;
  logic                  res_match, res_same, rng_exact, rng_ovl;
  logic [9:0]            a0, a1, b0, b1;
  logic [STAGE_BITS-1:0] msk;

  blmt_ram #(.WIDTH(RES_W), .DEPTH(RES_ENTRIES)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .re    (res_re),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  blmt_ram #(.WIDTH(RNG_W), .DEPTH(RNG_ENTRIES)) u_rng_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (rng_waddr),
    .wdata (rng_wdata),
    .re    (rng_re),
    .raddr (rng_raddr),
    .rdata (rng_rdata)
  );

  assign res_rd = res_rdata;
  assign rng_rd = rng_rdata;
  assign msk    = req.stage_mask[STAGE_BITS-1:0];

  always_comb begin
    is_res     = (item.mode == MODE_ADD_RES);
    is_rng     = (item.mode == MODE_ADD_RNG);
    scan_cnt   = is_res ? res_count : {{(RES_CW-RNG_CW){1'b0}}, rng_count};
    issue      = (state == S_SCAN) && (scan_idx < scan_cnt);
    scan_end   = (state == S_SCAN) && !pend && !issue;
    res_full   = (res_count == RES_CW'(RES_ENTRIES));
    rng_full   = (rng_count == RNG_CW'(RNG_ENTRIES));
    res_idx_ok = ({1'b0, req.entry_index} < res_count);
    rng_idx_ok = ({1'b0, req.entry_index} < {1'b0, rng_count});

    res_match = pend && (res_rd.set_number == item.set_number)
                && (res_rd.binding_number == item.binding_number);
    res_same  = (res_rd.resource_kind == item.resource_kind)
                && (res_rd.array_count == item.array_count);

    // half-open byte intervals, sums carried to 10 bits
    a0 = {2'b00, item.range_offset};
    a1 = a0 + {1'b0, item.range_bytes};
    b0 = {2'b00, rng_rd.range_offset};
    b1 = b0 + {1'b0, rng_rd.range_bytes};
    rng_exact = pend && (rng_rd.range_offset == item.range_offset)
                && (rng_rd.range_bytes == item.range_bytes);
    rng_ovl   = pend && (a0 < b1) && (b0 < a1);

    res_we    = 1'b0;
    res_re    = 1'b0;
    res_waddr = pend_idx;
    res_raddr = scan_idx[RES_AW-1:0];
    res_wdata = res_rd;
    res_wdata.stages = res_rd.stages | cur;
    rng_we    = 1'b0;
    rng_re    = 1'b0;
    rng_waddr = pend_idx[RNG_AW-1:0];
    rng_raddr = scan_idx[RNG_AW-1:0];
    rng_wdata = rng_rd;
    rng_wdata.stages = rng_rd.stages | cur;

    if (state == S_IDLE) begin
      res_raddr = req.entry_index[RES_AW-1:0];
      rng_raddr = req.entry_index[RNG_AW-1:0];
      res_re    = req_valid && (req.mode == MODE_RD_RES) && res_idx_ok;
      rng_re    = req_valid && (req.mode == MODE_RD_RNG) && rng_idx_ok;
    end else if (state == S_SCAN && is_res) begin
      res_re = issue;
      if (res_match) begin
        res_we = res_same;
      end else if (scan_end && !res_full) begin
        res_we    = 1'b1;
        res_waddr = res_count[RES_AW-1:0];
        res_wdata = '{set_number:     item.set_number,
                      binding_number: item.binding_number,
                      resource_kind:  item.resource_kind,
                      array_count:    item.array_count,
                      stages:         cur};
      end
    end else if (state == S_SCAN && is_rng) begin
      rng_re = issue;
      if (rng_exact) begin
        rng_we = 1'b1;
      end else if (scan_end && !ovl && !rng_full) begin
        rng_we    = 1'b1;
        rng_waddr = rng_count[RNG_AW-1:0];
        rng_wdata = '{range_offset: item.range_offset,
                      range_bytes:  item.range_bytes,
                      stages:       cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      err       <= ST_OK;
      res_count <= '0;
      rng_count <= '0;
      seen      <= '0;
      cur       <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item     <= req;
            rslt     <= '0;
            scan_idx <= '0;
            pend     <= 1'b0;
            ovl      <= 1'b0;
            unique case (req.mode) inside
              MODE_CLEAR: begin
                err       <= ST_OK;
                res_count <= '0;
                rng_count <= '0;
                seen      <= '0;
                cur       <= '0;
                state     <= S_DONE;
              end
              MODE_BEGIN: begin
                if (err == ST_OK) begin
                  if ((seen & msk) != '0) begin
                    err <= ST_DUP;
                  end else begin
                    seen <= seen | msk;
                    cur  <= msk;
                  end
                end
                state <= S_DONE;
              end
              MODE_ADD_RES, MODE_ADD_RNG: begin
                state <= (err == ST_OK) ? S_SCAN : S_DONE;
              end
              MODE_RD_RES: state <= res_idx_ok ? S_READ : S_DONE;
              MODE_RD_RNG: state <= rng_idx_ok ? S_READ : S_DONE;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          rslt.entry_valid <= 1'b1;
          if (item.mode == MODE_RD_RES) begin
            rslt.out_set         <= res_rd.set_number;
            rslt.out_binding     <= res_rd.binding_number;
            rslt.out_kind        <= res_rd.resource_kind;
            rslt.out_array_count <= res_rd.array_count;
            rslt.out_stages      <= res_rd.stages;
          end else begin
            rslt.out_offset <= rng_rd.range_offset;
            rslt.out_bytes  <= rng_rd.range_bytes;
            rslt.out_stages <= rng_rd.stages;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // one read issued per cycle, compare runs one entry behind
          pend     <= issue;
          pend_idx <= scan_idx[RES_AW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          ovl <= ovl | rng_ovl;
          if (is_res) begin
            if (res_match) begin
              if (res_rd.resource_kind != item.resource_kind) begin
                err <= ST_TYPE;
              end else if (res_rd.array_count != item.array_count) begin
                err <= ST_SIZE;
              end
              state <= S_DONE;
            end else if (scan_end) begin
              if (res_full) begin
                err <= ST_FULL;
              end else begin
                res_count <= res_count + 1'b1;
              end
              state <= S_DONE;
            end
          end else begin
            if (rng_exact) begin
              state <= S_DONE;
            end else if (scan_end) begin
              if (ovl) begin
                err <= ST_OVERLAP;
              end else if (rng_full) begin
                err <= ST_FULL;
              end else begin
                rng_count <= rng_count + 1'b1;
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE) && out_free;

  always_comb begin
    rsp        = rslt;
    rsp.status = err;
    unique case (item.mode) inside
      MODE_ADD_RES, MODE_RD_RES: rsp.entry_total = 5'(res_count);
      MODE_ADD_RNG, MODE_RD_RNG: rsp.entry_total = 5'(rng_count);
      default:                   rsp.entry_total = '0;
    endcase
  end

  `BLMT_ASSERT(a_res_rw_apart, clk, rst, !(res_we && res_re && (res_waddr == res_raddr)))
  `BLMT_ASSERT(a_rng_rw_apart, clk, rst, !(rng_we && rng_re && (rng_waddr == rng_raddr)))
  `BLMT_ASSERT_NEXT(a_err_held, clk, rst, (err != ST_OK) && !(req_valid && req_ready && (req.mode == MODE_CLEAR)), err == $past(err))
  `BLMT_ASSERT_NEXT(a_res_cnt_step, clk, rst, 1'b1, (res_count == $past(res_count)) || (res_count == $past(res_count) + 1'b1) || (res_count == '0))

endmodule

@@ src/binding_layout_merge_table_core.sv @@
// Channel   Dir  Fields
// s_*       in   tuser: mode; tdata: stage_mask .. entry_index
// m_*       out  tdata: status .. entry_total, one result per request
//
// Begin, clear, unused modes and reads at or past the count go straight to the
// done state; other reads pass through a read state first. Add requests walk the
// addressed table through its single RAM read port, or skip the walk while an
// error is latched.
// Reset clears counts, stage masks and the error latch; table RAMs are not
// cleared, entries at or above the count are never read.
// A finished result sits in the output register while the next request
// is accepted; the sequencer holds its next result until that slot frees.
module binding_layout_merge_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] stage_mask, [11:8] set_number, [21:12] binding_number,
  // [25:22] resource_kind, [41:26] array_count, [49:42] range_offset,
  // [58:50] range_bytes, [62:59] entry_index, [63] zero
  input  logic [blmt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [2:0] mode
  input  logic [blmt_pkg::MODE_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] status, [3] entry_valid, [7:4] out_set, [17:8] out_binding,
  // [21:18] out_kind, [37:22] out_array_count, [45:38] out_offset,
  // [54:46] out_bytes, [62:55] out_stages, [67:63] entry_total, [71:68] zero
  output logic [blmt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import blmt_pkg::*;

  req_t    req;
  result_t rsp;
  logic    rsp_valid;
  logic    out_free;

  always_comb begin
    req.mode           = mode_t'(s_tuser);
    req.stage_mask     = s_tdata[7:0];
    req.set_number     = s_tdata[11:8];
    req.binding_number = s_tdata[21:12];
    req.resource_kind  = s_tdata[25:22];
    req.array_count    = s_tdata[41:26];
    req.range_offset   = s_tdata[49:42];
    req.range_bytes    = s_tdata[58:50];
    req.entry_index    = s_tdata[62:59];
  end

  assign out_free = !m_tvalid || m_tready;

  blmt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req       (req),
    .req_ready (s_tready),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      m_tdata <= {4'b0000, rsp.entry_total, rsp.out_stages, rsp.out_bytes,
                  rsp.out_offset, rsp.out_array_count, rsp.out_kind,
                  rsp.out_binding, rsp.out_set, rsp.entry_valid, rsp.status};
    end
  end

endmodule

@@ tb/tb_binding_layout_merge_table_core.sv @@
`timescale 1ns / 1ps

module tb_binding_layout_merge_table_core;
  import blmt_pkg::*;

  // modes the block leaves unused; they must change nothing
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int RANDOM_REQS = 1350;
  localparam int BP_HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  binding_layout_merge_table_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow copy of both tables
  res_entry_t            res_tab [RES_ENTRIES];
  rng_entry_t            rng_tab [RNG_ENTRIES];
  int unsigned           res_cnt = 0;
  int unsigned           rng_cnt = 0;
  logic [STAGE_BITS-1:0] seen_stages_q = '0;
  logic [STAGE_BITS-1:0] cur_stage_q = '0;
  status_t               err_latch_q = ST_OK;

  result_t     outcome_q [$];
  int          fail_count = 0;
  int unsigned sent_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_req = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_tables();
    res_cnt = 0;
    rng_cnt = 0;
    seen_stages_q = '0;
    cur_stage_q = '0;
    err_latch_q = ST_OK;
  endfunction

  function automatic status_t merge_resource(req_t r);
    for (int i = 0; i < res_cnt; i++) begin
      if (res_tab[i].set_number == r.set_number &&
          res_tab[i].binding_number == r.binding_number) begin
        if (res_tab[i].resource_kind != r.resource_kind) return ST_TYPE;
        if (res_tab[i].array_count != r.array_count) return ST_SIZE;
        res_tab[i].stages |= cur_stage_q;
        return ST_OK;
      end
    end
    if (res_cnt >= RES_ENTRIES) return ST_FULL;
    res_tab[res_cnt] = '{r.set_number, r.binding_number, r.resource_kind,
                         r.array_count, cur_stage_q};
    res_cnt++;
    return ST_OK;
  endfunction

  function automatic status_t merge_range(req_t r);
    int unsigned a_start, a_end, b_start, b_end;
    a_start = 32'(r.range_offset);
    a_end = a_start + 32'(r.range_bytes);
    for (int i = 0; i < rng_cnt; i++) begin
      if (rng_tab[i].range_offset == r.range_offset &&
          rng_tab[i].range_bytes == r.range_bytes) begin
        rng_tab[i].stages |= cur_stage_q;
        return ST_OK;
      end
    end
    // overlap is checked before the full test
    for (int i = 0; i < rng_cnt; i++) begin
      b_start = 32'(rng_tab[i].range_offset);
      b_end = b_start + 32'(rng_tab[i].range_bytes);
      if (a_start < b_end && b_start < a_end) return ST_OVERLAP;
    end
    if (rng_cnt >= RNG_ENTRIES) return ST_FULL;
    rng_tab[rng_cnt] = '{r.range_offset, r.range_bytes, cur_stage_q};
    rng_cnt++;
    return ST_OK;
  endfunction

  function automatic result_t merge_outcome(req_t r);
    result_t o;
    logic [STAGE_BITS-1:0] m;
    o = '0;
    m = r.stage_mask[STAGE_BITS-1:0];
    case (r.mode)
      MODE_CLEAR: clear_tables();
      MODE_BEGIN: begin
        if (err_latch_q == ST_OK) begin
          if ((seen_stages_q & m) != 0) begin
            err_latch_q = ST_DUP;
          end else begin
            seen_stages_q |= m;
            cur_stage_q = m;
          end
        end
      end
      MODE_ADD_RES: begin
        if (err_latch_q == ST_OK) err_latch_q = merge_resource(r);
        o.entry_total = 5'(res_cnt);
      end
      MODE_ADD_RNG: begin
        if (err_latch_q == ST_OK) err_latch_q = merge_range(r);
        o.entry_total = 5'(rng_cnt);
      end
      MODE_RD_RES: begin
        if (32'(r.entry_index) < res_cnt) begin
          o.entry_valid     = 1'b1;
          o.out_set         = res_tab[r.entry_index].set_number;
          o.out_binding     = res_tab[r.entry_index].binding_number;
          o.out_kind        = res_tab[r.entry_index].resource_kind;
          o.out_array_count = res_tab[r.entry_index].array_count;
          o.out_stages      = res_tab[r.entry_index].stages;
        end
        o.entry_total = 5'(res_cnt);
      end
      MODE_RD_RNG: begin
        if (32'(r.entry_index) < rng_cnt) begin
          o.entry_valid = 1'b1;
          o.out_offset  = rng_tab[r.entry_index].range_offset;
          o.out_bytes   = rng_tab[r.entry_index].range_bytes;
          o.out_stages  = rng_tab[r.entry_index].stages;
        end
        o.entry_total = 5'(rng_cnt);
      end
      default: ;
    endcase
    o.status = err_latch_q;
    return o;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_request(req_t r);
    return {1'b0, r.entry_index, r.range_bytes, r.range_offset, r.array_count,
            r.resource_kind, r.binding_number, r.set_number, r.stage_mask};
  endfunction

  function automatic result_t unpack_result(logic [OUT_TDATA_W-1:0] d);
    result_t o;
    o.status          = status_t'(d[2:0]);
    o.entry_valid     = d[3];
    o.out_set         = d[7:4];
    o.out_binding     = d[17:8];
    o.out_kind        = d[21:18];
    o.out_array_count = d[37:22];
    o.out_offset      = d[45:38];
    o.out_bytes       = d[54:46];
    o.out_stages      = d[62:55];
    o.entry_total     = d[67:63];
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count < 10) $display("mismatch %s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_result(m_tdata);
      if (outcome_q.size() == 0) begin
        if (fail_count < 10) $display("mismatch: result %h with none expected", m_tdata);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
        check_field("out_set", 32'(want.out_set), 32'(got.out_set));
        check_field("out_binding", 32'(want.out_binding), 32'(got.out_binding));
        check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
        check_field("out_array_count", 32'(want.out_array_count),
                    32'(got.out_array_count));
        check_field("out_offset", 32'(want.out_offset), 32'(got.out_offset));
        check_field("out_bytes", 32'(want.out_bytes), 32'(got.out_bytes));
        check_field("out_stages", 32'(want.out_stages), 32'(got.out_stages));
        check_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
      end
    end
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 50);
  endfunction

  // result side: random stalls, plus a long hold-off on demand
  initial begin
    int hold_left, stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(req_t r);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_request(r);
    s_tuser  <= r.mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    outcome_q = {outcome_q, merge_outcome(r)};
    sent_count++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // unused fields carry random values so the block must ignore them
  function automatic req_t noise_req();
    req_t r;
    logic [2:0] m;
    m = 3'($urandom);
    r.mode           = mode_t'(m);
    r.stage_mask     = 8'($urandom);
    r.set_number     = 4'($urandom);
    r.binding_number = 10'($urandom);
    r.resource_kind  = 4'($urandom);
    r.array_count    = 16'($urandom);
    r.range_offset   = 8'($urandom);
    r.range_bytes    = 9'($urandom_range(0, 256));
    r.entry_index    = 4'($urandom);
    return r;
  endfunction

  function automatic req_t mk_mode(logic [2:0] md);
    req_t r;
    r = noise_req();
    r.mode = mode_t'(md);
    return r;
  endfunction

  function automatic req_t mk_begin(logic [7:0] mask);
    req_t r;
    r = mk_mode(MODE_BEGIN);
    r.stage_mask = mask;
    return r;
  endfunction

  function automatic req_t mk_res(logic [3:0] set, logic [9:0] bnd,
                                  logic [3:0] kind, logic [15:0] cnt);
    req_t r;
    r = mk_mode(MODE_ADD_RES);
    r.set_number     = set;
    r.binding_number = bnd;
    r.resource_kind  = kind;
    r.array_count    = cnt;
    return r;
  endfunction

  function automatic req_t mk_rng(logic [7:0] off, logic [8:0] bytes);
    req_t r;
    r = mk_mode(MODE_ADD_RNG);
    r.range_offset = off;
    r.range_bytes  = bytes;
    return r;
  endfunction

  function automatic req_t mk_read(mode_t md, logic [3:0] idx);
    req_t r;
    r = mk_mode(md);
    r.entry_index = idx;
    return r;
  endfunction

  function automatic mode_t pick_read();
    return ($urandom_range(0, 1) != 0) ? MODE_RD_RES : MODE_RD_RNG;
  endfunction

  task automatic test_resource_merge();
    send_request(mk_read(MODE_RD_RES, 4'd0));
    send_request(mk_res(4'h0, 10'h000, 4'h0, 16'h0000));  // no stage yet
    send_request(mk_begin(8'h01));
    send_request(mk_res(4'hF, 10'h3FF, 4'hF, 16'hFFFF));
    send_request(mk_res(4'h0, 10'h000, 4'h0, 16'h0000));
    send_request(mk_begin(8'hC0));
    send_request(mk_res(4'hF, 10'h3FF, 4'hF, 16'hFFFF));
    send_request(mk_res(4'h5, 10'h200, 4'h3, 16'h8000));
    send_request(mk_begin(8'h00));
    send_request(mk_res(4'hA, 10'h155, 4'hA, 16'h5555));
    for (int i = 0; i < 5; i++) send_request(mk_read(MODE_RD_RES, 4'(i)));
    send_request(mk_read(MODE_RD_RES, 4'hF));
    drain();
  endtask

  task automatic test_push_ranges();
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_begin(8'h10));
    send_request(mk_rng(8'd0, 9'd0));
    send_request(mk_rng(8'd0, 9'd0));
    send_request(mk_rng(8'd0, 9'd16));
    send_request(mk_rng(8'd16, 9'd0));
    send_request(mk_begin(8'h20));
    send_request(mk_rng(8'd0, 9'd16));
    send_request(mk_rng(8'd255, 9'd1));
    send_request(mk_rng(8'd200, 9'd56));  // overlaps the last byte
    send_request(mk_rng(8'd100, 9'd4));   // blocked by the latch
    for (int i = 0; i < 5; i++) send_request(mk_read(MODE_RD_RNG, 4'(i)));
    send_request(mk_read(MODE_RD_RNG, 4'hF));
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_rng(8'd0, 9'd256));
    send_request(mk_read(MODE_RD_RNG, 4'd0));
    drain();
  endtask

  task automatic test_error_latch();
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_begin(8'h01));
    send_request(mk_begin(8'h03));
    send_request(mk_begin(8'h80));
    send_request(mk_res(4'h1, 10'h001, 4'h2, 16'd10));
    send_request(mk_read(MODE_RD_RES, 4'd0));
    send_request(mk_mode(MODE_SPARE_A));
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_res(4'h1, 10'h001, 4'h2, 16'd10));
    send_request(mk_res(4'h1, 10'h001, 4'h3, 16'd10));
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_res(4'h1, 10'h001, 4'h2, 16'd10));
    send_request(mk_res(4'h1, 10'h001, 4'h2, 16'd11));
    send_request(mk_read(MODE_RD_RES, 4'd0));
    send_request(mk_mode(MODE_SPARE_B));
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_mode(MODE_SPARE_B));
    drain();
  endtask

  task automatic fill_ranges();
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_begin(8'h04));
    for (int i = 0; i < RNG_ENTRIES; i++) send_request(mk_rng(8'(i * 32), 9'd32));
  endtask

  task automatic test_table_full();
    send_request(mk_mode(MODE_CLEAR));
    send_request(mk_begin(8'h08));
    for (int i = 0; i < RES_ENTRIES; i++) begin
      send_request(mk_res(4'(i), 10'(i * 3), 4'(i), 16'(i * 100)));
    end
    send_request(mk_res(4'h0, 10'h3FF, 4'h1, 16'd7));
    send_request(mk_read(MODE_RD_RES, 4'hF));
    fill_ranges();
    send_request(mk_rng(8'd32, 9'd32));
    send_request(mk_rng(8'd0, 9'd0));     // no overlap, table full
    fill_ranges();
    send_request(mk_rng(8'd8, 9'd4));     // overlap wins over full
    send_request(mk_read(MODE_RD_RNG, 4'd7));
    drain();
  endtask

  // one clear, then stages of adds (bindings from a small pool) and reads
  task automatic run_session();
    logic [3:0]  kset [20];
    logic [9:0]  kbind [20];
    logic [3:0]  kkind [20];
    logic [15:0] kcnt [20];
    int          nkeys, k, b, slot, op;
    logic [7:0]  used, bitm;
    req_t        r;
    nkeys = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(2, 8);
    for (int i = 0; i < nkeys; i++) begin
      kset[i]  = 4'($urandom);
      kbind[i] = 10'($urandom);
      kkind[i] = 4'($urandom);
      kcnt[i]  = 16'($urandom);
    end
    tx_idle_en = ($urandom_range(0, 4) != 0);
    rx_idle_en = ($urandom_range(0, 4) != 0);
    send_request(mk_mode(MODE_CLEAR));
    used = '0;
    repeat ($urandom_range(1, 8)) begin
      if (used == 8'hFF || $urandom_range(0, 19) == 0) begin
        bitm = 8'($urandom);
      end else begin
        do b = $urandom_range(0, 7); while (used[b]);
        bitm = 8'h01 << b;
      end
      used |= bitm;
      send_request(mk_begin(bitm));
      repeat ($urandom_range(1, 6)) begin
        op = $urandom_range(0, 99);
        if (op < 55) begin
          k = $urandom_range(0, nkeys - 1);
          r = mk_res(kset[k], kbind[k], kkind[k], kcnt[k]);
          if ($urandom_range(0, 99) < 3) r.resource_kind = 4'($urandom);
          if ($urandom_range(0, 99) < 3) r.array_count = 16'($urandom);
        end else if (op < 85) begin
          slot = $urandom_range(0, 9);
          r = mk_rng(8'(slot * 24), 9'd24);
          if ($urandom_range(0, 9) == 0) begin
            r.range_offset = 8'($urandom);
            r.range_bytes  = 9'($urandom_range(0, 256));
          end
        end else if (op < 97) begin
          r = mk_read(pick_read(), 4'($urandom));
        end else begin
          r = noise_req();
        end
        send_request(r);
      end
    end
    repeat (3) send_request(mk_read(pick_read(), 4'($urandom)));
  endtask

  task automatic test_random_sessions();
    int unsigned stop_at;
    stop_at = sent_count + RANDOM_REQS;
    while (sent_count < stop_at) run_session();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain();
  endtask

  // result side holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    req_t r;
    tx_idle_en = 1'b0;
    send_request(mk_mode(MODE_CLEAR));
    rx_hold_req = BP_HOLD_CYCLES;
    send_request(mk_begin(8'h02));
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 2))
        0: r = mk_res(4'($urandom_range(0, 3)), 10'($urandom_range(0, 3)), 4'h1, 16'd4);
        1: r = mk_rng(8'($urandom_range(0, 7) * 32), 9'd32);
        default: r = mk_read(pick_read(), 4'($urandom));
      endcase
      send_request(r);
    end
    tx_idle_en = 1'b1;
    drain();
  endtask

  initial begin
    clear_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_resource_merge();
    test_push_ranges();
    test_error_latch();
    test_table_full();
    test_random_sessions();
    test_backpressure();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
